[sv/scbpm_pkg.sv]
// Shared types, constants and helper functions for the size-class block pool manager.
package scbpm_pkg;

    localparam int NUM_BUCKETS = 32;
    localparam int NUM_CPUS    = 8;
    localparam int SLOT_DEPTH  = 16;
    localparam int HANDLE_BITS = 48;

    localparam int SIZE_W  = 41;
    localparam int BKT_W   = $clog2(NUM_BUCKETS);
    localparam int RAW_W   = 6;
    localparam int CPU_W   = $clog2(NUM_CPUS);
    localparam int DEPTH_W = $clog2(SLOT_DEPTH);
    localparam int CNT_W   = DEPTH_W + 1;
    localparam int ROW_W   = NUM_CPUS * CNT_W;
    localparam int STK_AW  = BKT_W + CPU_W + DEPTH_W;
    localparam int STK_DEPTH = NUM_BUCKETS * NUM_CPUS * SLOT_DEPTH;

    // Opcodes of the command word.
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_RESIZE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_MAX_POOLED = 1'b0;
    localparam logic REG_SLOT_CAP   = 1'b1;

    // Outcome codes of a result word.
    localparam logic [2:0] OUT_HIT_LOCAL  = 3'd0;
    localparam logic [2:0] OUT_HIT_STOLEN = 3'd1;
    localparam logic [2:0] OUT_MISS       = 3'd2;
    localparam logic [2:0] OUT_FETCH      = 3'd3;
    localparam logic [2:0] OUT_POOLED     = 3'd4;
    localparam logic [2:0] OUT_RELEASE    = 3'd5;
    localparam logic [2:0] OUT_IN_PLACE   = 3'd6;
    localparam logic [2:0] OUT_NULL       = 3'd7;

    typedef enum logic [1:0] {
        UOP_DIRECT,
        UOP_ALLOC,
        UOP_FREE
    } uop_kind_t;

    // One unit of work passed from the front part to the back part.
    typedef struct packed {
        uop_kind_t               kind;
        logic [2:0]              outcome;
        logic [HANDLE_BITS-1:0]  handle;
        logic [BKT_W-1:0]        bucket;
        logic [CPU_W-1:0]        cpu;
        logic [SIZE_W-1:0]       fetch;
        logic                    last;
    } uop_t;

    // One result word.
    typedef struct packed {
        logic                    valid;
        logic [2:0]              outcome;
        logic [HANDLE_BITS-1:0]  handle;
        logic [BKT_W-1:0]        bucket;
        logic [SIZE_W-1:0]       fetch;
        logic                    last;
    } res_t;

    // Unclamped ceiling of log2, zero for sizes of one or less.
    function automatic logic [RAW_W-1:0] raw_bucket(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] v;
        logic [RAW_W-1:0]  b;
        v = sz - SIZE_W'(1);
        b = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (v[i])
            begin
                b = RAW_W'(i + 1);
            end
        end
        if (sz <= SIZE_W'(1))
        begin
            b = '0;
        end
        return b;
    endfunction

    function automatic logic [BKT_W-1:0] clamp_bucket(input logic [RAW_W-1:0] raw);
        logic [BKT_W-1:0] b;
        if (raw < RAW_W'(NUM_BUCKETS))
        begin
            b = raw[BKT_W-1:0];
        end
        else
        begin
            b = BKT_W'(NUM_BUCKETS - 1);
        end
        return b;
    endfunction

endpackage

[sv/scbpm_front.sv]
// Front part: latches a command word and splits it into pool operations.
module scbpm_front
    import scbpm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [1:0]             opcode,
    input  logic [SIZE_W-1:0]      req_size,
    input  logic [SIZE_W-1:0]      prior_size,
    input  logic [HANDLE_BITS-1:0] block_handle,
    input  logic [CPU_W-1:0]       req_cpu,
    input  logic [SIZE_W-1:0]      max_pooled,
    output logic                   front_busy,
    output logic [1:0]             push_cnt,
    output uop_t                   push0,
    output uop_t                   push1
);

    logic                   vld_reg;
    logic [1:0]             op_reg;
    logic [SIZE_W-1:0]      nsz_reg;
    logic [SIZE_W-1:0]      osz_reg;
    logic [HANDLE_BITS-1:0] h_reg;
    logic [CPU_W-1:0]       cpu_reg;

    logic [RAW_W-1:0] n_raw;
    logic [RAW_W-1:0] o_raw;
    logic [BKT_W-1:0] n_bkt;
    logic [BKT_W-1:0] o_bkt;
    logic             n_pool;
    logic             o_pool;
    uop_t             alloc_n;
    uop_t             alloc_n0;
    uop_t             free_n;
    uop_t             free_o;
    uop_t             in_place;

    // Command register; valid is cleared on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            nsz_reg <= req_size;
            osz_reg <= prior_size;
            h_reg   <= block_handle;
            cpu_reg <= req_cpu;
        end
    end

    assign front_busy = vld_reg;

    // Size classes and poolability of both sizes.
    always_comb
    begin
        n_raw  = raw_bucket(nsz_reg);
        o_raw  = raw_bucket(osz_reg);
        n_bkt  = clamp_bucket(n_raw);
        o_bkt  = clamp_bucket(o_raw);
        n_pool = (nsz_reg != '0) && (nsz_reg <= max_pooled)
                 && (n_raw <= RAW_W'(NUM_BUCKETS - 1));
        o_pool = (osz_reg != '0) && (osz_reg <= max_pooled)
                 && (o_raw <= RAW_W'(NUM_BUCKETS - 1));
    end

    // Candidate operations: alloc of the new size, free of either size, in place.
    always_comb
    begin
        alloc_n.kind    = n_pool ? UOP_ALLOC : UOP_DIRECT;
        alloc_n.outcome = OUT_FETCH;
        alloc_n.handle  = '0;
        alloc_n.bucket  = n_bkt;
        alloc_n.cpu     = cpu_reg;
        alloc_n.fetch   = nsz_reg;
        alloc_n.last    = 1'b1;

        alloc_n0      = alloc_n;
        alloc_n0.last = 1'b0;

        free_n.cpu  = cpu_reg;
        free_n.last = 1'b1;
        free_n.fetch = '0;
        if (h_reg == '0)
        begin
            free_n.kind    = UOP_DIRECT;
            free_n.outcome = OUT_NULL;
            free_n.handle  = '0;
            free_n.bucket  = '0;
        end
        else
        begin
            free_n.kind    = n_pool ? UOP_FREE : UOP_DIRECT;
            free_n.outcome = OUT_RELEASE;
            free_n.handle  = h_reg;
            free_n.bucket  = n_bkt;
        end

        free_o = free_n;
        if (h_reg != '0)
        begin
            free_o.kind   = o_pool ? UOP_FREE : UOP_DIRECT;
            free_o.bucket = o_bkt;
        end

        in_place.kind    = UOP_DIRECT;
        in_place.outcome = OUT_IN_PLACE;
        in_place.handle  = h_reg;
        in_place.bucket  = n_bkt;
        in_place.cpu     = cpu_reg;
        in_place.fetch   = '0;
        in_place.last    = 1'b1;
    end

    // Operation selection by opcode.
    always_comb
    begin
        push_cnt = 2'd0;
        push0    = alloc_n;
        push1    = free_o;
        if (vld_reg)
        begin
            unique case (op_reg)
                OP_ALLOC:
                begin
                    push_cnt = 2'd1;
                    push0    = alloc_n;
                end
                OP_FREE:
                begin
                    push_cnt = 2'd1;
                    push0    = free_n;
                end
                OP_RESIZE:
                begin
                    priority if (h_reg == '0)
                    begin
                        push_cnt = 2'd1;
                        push0    = alloc_n;
                    end
                    else if (nsz_reg == '0)
                    begin
                        push_cnt = 2'd1;
                        push0    = free_o;
                    end
                    else if (n_pool && o_pool && (n_bkt == o_bkt))
                    begin
                        push_cnt = 2'd1;
                        push0    = in_place;
                    end
                    else
                    begin
                        push_cnt = 2'd2;
                        push0    = alloc_n0;
                        push1    = free_o;
                    end
                end
                default:
                begin
                    push_cnt = 2'd0;
                end
            endcase
        end
    end

endmodule

[sv/scbpm_queue.sv]
// Short operation queue between the front and back parts; takes up to two words a cycle.
module scbpm_queue
    import scbpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  uop_t       push0,
    input  uop_t       push1,
    input  logic       pop,
    output logic       empty,
    output uop_t       head
);

    uop_t       q_mem [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + push_cnt;
            rp_reg  <= rp_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, push_cnt} - {2'b0, pop};
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            q_mem[wp_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            q_mem[wp_reg + 2'd1] <= push1;
        end
    end

    assign empty = (cnt_reg == '0);
    assign head  = q_mem[rp_reg];

endmodule

[sv/scbpm_back.sv]
// Back part: slot count rows, handle stacks, and result words.
module scbpm_back
    import scbpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  uop_t       head,
    input  logic [4:0] slot_cap,
    output logic       pop,
    output logic       back_busy,
    output res_t       res
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_PICK,
        B_POP
    } bstate_t;

    bstate_t                state_reg;
    uop_t                   cur_reg;
    res_t                   res_reg;
    logic                   stolen_reg;
    logic [NUM_BUCKETS-1:0] row_vld_reg;
    logic                   row_rdv_reg;
    logic [ROW_W-1:0]       row_rd_reg;
    logic [HANDLE_BITS-1:0] stk_rd_reg;

    logic [ROW_W-1:0]       row_mem [NUM_BUCKETS];
    logic [HANDLE_BITS-1:0] stk_mem [STK_DEPTH];

    logic [ROW_W-1:0]  row_cur;
    logic [ROW_W-1:0]  row_wr;
    logic              row_we;
    logic              found;
    logic              local_hit;
    logic [CPU_W-1:0]  sel_cpu;
    logic [CNT_W-1:0]  sel_cnt;
    logic [CPU_W-1:0]  c;
    logic [CNT_W-1:0]  cnt_i;
    logic [CNT_W-1:0]  own_cnt;
    logic [CNT_W-1:0]  cap;
    logic              free_ok;
    logic              stk_we;
    logic              stk_re;
    logic [STK_AW-1:0] stk_addr;

    assign pop       = (state_reg == B_IDLE) && !empty;
    assign back_busy = (state_reg != B_IDLE);
    assign res       = res_reg;

    // Pick a slot in the current bucket row and work out the row update.
    always_comb
    begin
        row_cur   = row_rdv_reg ? row_rd_reg : '0;
        found     = 1'b0;
        local_hit = 1'b0;
        sel_cpu   = cur_reg.cpu;
        sel_cnt   = '0;
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            c     = cur_reg.cpu + CPU_W'(i);
            cnt_i = row_cur[c*CNT_W +: CNT_W];
            if (!found && (cnt_i != '0) && (cnt_i <= CNT_W'(SLOT_DEPTH)))
            begin
                found     = 1'b1;
                local_hit = (i == 0);
                sel_cpu   = c;
                sel_cnt   = cnt_i;
            end
        end
        own_cnt = row_cur[cur_reg.cpu*CNT_W +: CNT_W];
        cap     = (slot_cap < CNT_W'(SLOT_DEPTH)) ? slot_cap : CNT_W'(SLOT_DEPTH);
        free_ok = (own_cnt < cap);

        row_wr   = row_cur;
        row_we   = 1'b0;
        stk_we   = 1'b0;
        stk_re   = 1'b0;
        stk_addr = {cur_reg.bucket, sel_cpu, DEPTH_W'(sel_cnt - CNT_W'(1))};
        if (state_reg == B_PICK)
        begin
            if (cur_reg.kind == UOP_ALLOC)
            begin
                if (found)
                begin
                    row_wr[sel_cpu*CNT_W +: CNT_W] = sel_cnt - CNT_W'(1);
                    row_we = 1'b1;
                    stk_re = 1'b1;
                end
            end
            else if (free_ok)
            begin
                row_wr[cur_reg.cpu*CNT_W +: CNT_W] = own_cnt + CNT_W'(1);
                row_we   = 1'b1;
                stk_we   = 1'b1;
                stk_addr = {cur_reg.bucket, cur_reg.cpu, own_cnt[DEPTH_W-1:0]};
            end
        end
    end

    // Sequencer with the registered result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            res_reg     <= '0;
            row_vld_reg <= '0;
            row_rdv_reg <= 1'b0;
            stolen_reg  <= 1'b0;
        end
        else
        begin
            res_reg.valid <= 1'b0;
            if (row_we)
            begin
                row_vld_reg[cur_reg.bucket] <= 1'b1;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        if (head.kind == UOP_DIRECT)
                        begin
                            res_reg.valid   <= 1'b1;
                            res_reg.outcome <= head.outcome;
                            res_reg.handle  <= head.handle;
                            res_reg.bucket  <= head.bucket;
                            res_reg.fetch   <= head.fetch;
                            res_reg.last    <= head.last;
                        end
                        else
                        begin
                            row_rdv_reg <= row_vld_reg[head.bucket];
                            state_reg   <= B_PICK;
                        end
                    end
                end
                B_PICK:
                begin
                    res_reg.handle <= '0;
                    res_reg.bucket <= cur_reg.bucket;
                    res_reg.fetch  <= '0;
                    res_reg.last   <= cur_reg.last;
                    if (cur_reg.kind == UOP_ALLOC)
                    begin
                        if (found)
                        begin
                            stolen_reg <= !local_hit;
                            state_reg  <= B_POP;
                        end
                        else
                        begin
                            res_reg.valid   <= 1'b1;
                            res_reg.outcome <= OUT_MISS;
                            res_reg.fetch   <= SIZE_W'(1) << cur_reg.bucket;
                            state_reg       <= B_IDLE;
                        end
                    end
                    else
                    begin
                        res_reg.valid <= 1'b1;
                        if (free_ok)
                        begin
                            res_reg.outcome <= OUT_POOLED;
                        end
                        else
                        begin
                            res_reg.outcome <= OUT_RELEASE;
                            res_reg.handle  <= cur_reg.handle;
                        end
                        state_reg <= B_IDLE;
                    end
                end
                B_POP:
                begin
                    res_reg.valid   <= 1'b1;
                    res_reg.outcome <= stolen_reg ? OUT_HIT_STOLEN : OUT_HIT_LOCAL;
                    res_reg.handle  <= stk_rd_reg;
                    state_reg       <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Current operation register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    // Slot count rows: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[cur_reg.bucket] <= row_wr;
        end
        if (pop)
        begin
            row_rd_reg <= row_mem[head.bucket];
        end
    end

    // Handle stacks: one access a cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_addr] <= cur_reg.handle;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_addr];
        end
    end

endmodule

[sv/size_class_block_pool_manager.sv]
// Top level of the size-class block pool manager.
//
// Commands: a word is taken at a rising edge with start high and busy low.
// opcode selects alloc, free or resize; sizes map to power-of-two buckets,
// and free handles are held in per-bucket, per-CPU stacks of SLOT_DEPTH.
// Configuration: wr_en, wr_index and wr_data write max_pooled_bytes (index 0)
// or slot_cap (index 1); write only while busy is low.
// Results: done marks each result word for exactly one cycle; the receiver
// cannot hold results off, so none is ever stalled. A resize of a non-null
// handle to a nonzero size gives two words, an alloc word then a free word,
// unless both sizes pool into the same bucket; last_result marks the final
// word of each command. Flow: a command passes the front register, then the
// queue; then a direct result is registered from the queue head, a free or
// a miss takes a count row read, then pick and update, and a pop hit adds
// the stack read. busy stays high until a command's last word has been
// registered. The registered reads of the count row memory and the stack port set these steps.
// Reset clears the count row valid bits, so all slots read as empty at once;
// no clearing pass is needed.
module size_class_block_pool_manager
    import scbpm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   wr_en,
    input  logic                   wr_index,
    input  logic [SIZE_W-1:0]      wr_data,
    input  logic [1:0]             opcode,
    input  logic [SIZE_W-1:0]      req_size,
    input  logic [SIZE_W-1:0]      prior_size,
    input  logic [HANDLE_BITS-1:0] block_handle,
    input  logic [CPU_W-1:0]       req_cpu,
    output logic                   done,
    output logic [2:0]             outcome,
    output logic [HANDLE_BITS-1:0] result_handle,
    output logic [BKT_W-1:0]       bucket_index,
    output logic [SIZE_W-1:0]      fetch_bytes,
    output logic                   last_result
);

    logic [SIZE_W-1:0] max_pooled_reg;
    logic [4:0]        slot_cap_reg;
    logic              accept;
    logic              front_busy;
    logic              back_busy;
    logic [1:0]        push_cnt;
    uop_t              push0;
    uop_t              push1;
    logic              q_empty;
    logic              pop;
    uop_t              head;
    res_t              res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pooled_reg <= SIZE_W'(64'd16777216);
            slot_cap_reg   <= 5'd16;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MAX_POOLED: max_pooled_reg <= wr_data;
                REG_SLOT_CAP:   slot_cap_reg   <= wr_data[4:0];
                default:        slot_cap_reg   <= slot_cap_reg;
            endcase
        end
    end

    assign busy   = front_busy || !q_empty || back_busy;
    assign accept = start && !busy;

    scbpm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .opcode       (opcode),
        .req_size     (req_size),
        .prior_size   (prior_size),
        .block_handle (block_handle),
        .req_cpu      (req_cpu),
        .max_pooled   (max_pooled_reg),
        .front_busy   (front_busy),
        .push_cnt     (push_cnt),
        .push0        (push0),
        .push1        (push1)
    );

    scbpm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (push0),
        .push1    (push1),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    scbpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head),
        .slot_cap  (slot_cap_reg),
        .pop       (pop),
        .back_busy (back_busy),
        .res       (res)
    );

    assign done          = res.valid;
    assign outcome       = res.outcome;
    assign result_handle = res.handle;
    assign bucket_index  = res.bucket;
    assign fetch_bytes   = res.fetch;
    assign last_result   = res.last;

endmodule
